/* sv/psab_pkg.sv */
`default_nettype none

package psab_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned LIN_W      = 17;

  localparam logic [CFG_IDX_W-1:0]  CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] DIM_RESET        = 9'd256;

  typedef enum logic [1:0] {
    OP_ACC  = 2'd0,
    OP_RES  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_DIV,
    S_WB,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] column;
    logic [7:0] row_index;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic load;
    logic look;
    logic acc_wr;
    logic div_start;
    logic div_step;
    logic wb_wr;
    logic clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       oor;
    logic       cnt_zero;
    logic       div_last;
    logic       clr_last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

/* sv/psab_ram.sv */
`default_nettype none

module psab_ram #(
  parameter int unsigned WIDTH = 57,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/psab_div.sv */
`default_nettype none

module psab_div #(
  parameter int unsigned DW = 16,
  parameter int unsigned VW = 9
) (
  input  wire logic          clk_i,
  input  wire logic          start_i,
  input  wire logic          step_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic      [DW-1:0] quot_o
);

  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dsr_q, dsr_d;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          ge;

  // one quotient bit per step, restoring form
  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    diff   = rem_sh - {1'b0, dsr_q};
    ge     = (rem_sh >= {1'b0, dsr_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (step_i) begin
      quo_d = {quo_q[DW-2:0], ge};
      rem_d = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quot_o = quo_q;

endmodule

`default_nettype wire

/* sv/psab_ctrl.sv */
`default_nettype none

module psab_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire psab_pkg::sts_t  sts_i,
  output psab_pkg::cmd_t       cmd_o
);

  import psab_pkg::*;

  state_e state_q, state_d;
  logic   do_div;

  assign do_div = (sts_i.op == OP_RES) && !sts_i.oor && !sts_i.cnt_zero;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (sts_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_LOOK;
      S_LOOK:  state_d = S_EXEC;
      S_EXEC:  state_d = do_div ? S_DIV : S_RESP;
      S_DIV:   if (sts_i.div_last) state_d = S_WB;
      S_WB:    state_d = S_RESP;
      S_RESP:  if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: cmd_o.clr = 1'b1;
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_LOOK: cmd_o.look = 1'b1;
      S_EXEC: begin
        cmd_o.acc_wr    = (sts_i.op == OP_ACC) && !sts_i.oor;
        cmd_o.div_start = do_div;
      end
      S_DIV:   cmd_o.div_step = 1'b1;
      S_WB:    cmd_o.wb_wr = 1'b1;
      S_RESP:  cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* sv/psab_dp.sv */
`default_nettype none

module psab_dp #(
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned COUNT_BITS = 9,
  parameter int unsigned SUM_BITS   = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [psab_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [psab_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire psab_pkg::in_t                       in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output psab_pkg::out_t                           out_data_o,
  input  wire psab_pkg::cmd_t                      cmd_i,
  output psab_pkg::sts_t                           sts_o
);

  import psab_pkg::*;

  localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned EW     = 3 * SUM_BITS + COUNT_BITS;
  localparam int unsigned CW     = $clog2(SUM_BITS);

  logic [CFG_DATA_W-1:0] width_q, height_q;
  in_t                   item_q;
  logic [ADDR_W-1:0]     addr_q, clr_q;
  logic                  oor_q, oor_d;
  logic [CW-1:0]         div_cnt_q;
  logic                  out_valid_q;
  out_t                  out_q, res;

  logic [LIN_W-1:0]      lin;
  logic [31:0]           lin32;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [EW-1:0]         ram_wdata, rdata;

  logic [SUM_BITS-1:0]   rd_r, rd_g, rd_b;
  logic [COUNT_BITS-1:0] rd_cnt, new_cnt;
  logic [SUM_BITS:0]     acc_r, acc_g, acc_b;
  logic [SUM_BITS-1:0]   new_r, new_g, new_b;
  logic                  acc_sat;
  logic [SUM_BITS-1:0]   q_r, q_g, q_b;
  logic                  big_r, big_g, big_b;

  // linear address and range check of the held item
  always_comb begin
    lin   = LIN_W'(item_q.row_index) * LIN_W'(width_q) + LIN_W'(item_q.column);
    lin32 = 32'(lin);
    oor_d = ({1'b0, item_q.column} >= width_q)
         || ({1'b0, item_q.row_index} >= height_q)
         || (lin32 >= 32'(MAX_PIXELS));
  end

  assign rd_r   = rdata[SUM_BITS-1:0];
  assign rd_g   = rdata[2*SUM_BITS-1:SUM_BITS];
  assign rd_b   = rdata[3*SUM_BITS-1:2*SUM_BITS];
  assign rd_cnt = rdata[EW-1:3*SUM_BITS];

  // saturating accumulate
  always_comb begin
    acc_r   = {1'b0, rd_r} + (SUM_BITS+1)'(item_q.in_red);
    acc_g   = {1'b0, rd_g} + (SUM_BITS+1)'(item_q.in_green);
    acc_b   = {1'b0, rd_b} + (SUM_BITS+1)'(item_q.in_blue);
    new_r   = acc_r[SUM_BITS] ? '1 : acc_r[SUM_BITS-1:0];
    new_g   = acc_g[SUM_BITS] ? '1 : acc_g[SUM_BITS-1:0];
    new_b   = acc_b[SUM_BITS] ? '1 : acc_b[SUM_BITS-1:0];
    new_cnt = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
    acc_sat = acc_r[SUM_BITS] || acc_g[SUM_BITS] || acc_b[SUM_BITS] || (&rd_cnt);
  end

  psab_div #(.DW(SUM_BITS), .VW(COUNT_BITS)) u_div_r (
    .clk_i, .start_i(cmd_i.div_start), .step_i(cmd_i.div_step),
    .dividend_i(rd_r), .divisor_i(rd_cnt), .quot_o(q_r)
  );
  psab_div #(.DW(SUM_BITS), .VW(COUNT_BITS)) u_div_g (
    .clk_i, .start_i(cmd_i.div_start), .step_i(cmd_i.div_step),
    .dividend_i(rd_g), .divisor_i(rd_cnt), .quot_o(q_g)
  );
  psab_div #(.DW(SUM_BITS), .VW(COUNT_BITS)) u_div_b (
    .clk_i, .start_i(cmd_i.div_start), .step_i(cmd_i.div_step),
    .dividend_i(rd_b), .divisor_i(rd_cnt), .quot_o(q_b)
  );

  // store write port: clearing sweep, accumulate, or resolve write-back
  always_comb begin
    ram_we    = cmd_i.clr || cmd_i.acc_wr || cmd_i.wb_wr;
    ram_waddr = cmd_i.clr ? clr_q : addr_q;
    if (cmd_i.clr) begin
      ram_wdata = '0;
    end else if (cmd_i.wb_wr) begin
      ram_wdata = {COUNT_BITS'(1), q_b, q_g, q_r};
    end else begin
      ram_wdata = {new_cnt, new_b, new_g, new_r};
    end
  end

  psab_ram #(.WIDTH(EW), .DEPTH(MAX_PIXELS)) u_store (
    .clk_i,
    .we_i(ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i(cmd_i.look),
    .raddr_i(lin32[ADDR_W-1:0]),
    .rdata_o(rdata)
  );

  // result of the held transaction
  always_comb begin
    big_r = (q_r > SUM_BITS'(255));
    big_g = (q_g > SUM_BITS'(255));
    big_b = (q_b > SUM_BITS'(255));
    res   = '0;
    if (item_q.operation == OP_NOP) begin
      res = '0;
    end else if (oor_q) begin
      res.status = ST_RANGE;
    end else begin
      case (item_q.operation)
        OP_ACC: res.status = acc_sat ? ST_SAT : ST_OK;
        OP_READ: begin
          res.out_red   = rd_r[7:0];
          res.out_green = rd_g[7:0];
          res.out_blue  = rd_b[7:0];
        end
        OP_RES: begin
          if (rd_cnt != '0) begin
            res.out_red   = big_r ? 8'hFF : q_r[7:0];
            res.out_green = big_g ? 8'hFF : q_g[7:0];
            res.out_blue  = big_b ? 8'hFF : q_b[7:0];
            res.status    = (big_r || big_g || big_b) ? ST_SAT : ST_OK;
          end
        end
        default: res = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= DIM_RESET;
      height_q    <= DIM_RESET;
      clr_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.look) begin
      addr_q <= lin32[ADDR_W-1:0];
      oor_q  <= oor_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res;
    end
  end

  always_comb begin
    sts_o.op       = item_q.operation;
    sts_o.oor      = oor_q;
    sts_o.cnt_zero = (rd_cnt == '0);
    sts_o.div_last = (div_cnt_q == CW'(SUM_BITS - 1));
    sts_o.clr_last = (clr_q == ADDR_W'(MAX_PIXELS - 1));
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* sv/pixel_sample_accumulation_buffer_core.sv */
// Per-pixel color accumulation store for supersampled rendering.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries one transaction:
// an operation (accumulate, resolve, read) and a pixel column/row. The pixel
// address is row_index * image_width + column; image_width and image_height
// are set through the plain write port (cfg_we_i, cfg_idx_i, cfg_data_i).
// Output channel (out_valid_o/out_ready_i, out_data_o) returns exactly one
// result per transaction, in order, from an output register.
// Transactions are handled one at a time. Accumulate, read and rejected
// transactions pass through a look-up, an execute and a response state;
// the pixel store is read and then written through one RAM with a
// registered read. Resolve adds a divide and a write-back state: a
// restoring divider per color retires one quotient bit per cycle.
// After reset the block sweeps all MAX_PIXELS entries of the store to zero,
// one entry per cycle, with in_ready_o low; configuration writes are taken
// throughout. A stalled receiver holds the result in the output register;
// the next transaction is accepted and processed meanwhile, and waits for
// the register to drain only before handing over its own result.
`default_nettype none

module pixel_sample_accumulation_buffer_core #(
  parameter int unsigned MAX_PIXELS = 65536,
  parameter int unsigned COUNT_BITS = 9,
  parameter int unsigned SUM_BITS   = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [psab_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [psab_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire psab_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output psab_pkg::out_t                       out_data_o
);

  import psab_pkg::*;

  cmd_t cmd;
  sts_t sts;

  psab_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sts_i(sts),
    .cmd_o(cmd)
  );

  psab_dp #(
    .MAX_PIXELS(MAX_PIXELS),
    .COUNT_BITS(COUNT_BITS),
    .SUM_BITS(SUM_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cmd_i(cmd),
    .sts_o(sts)
  );

  // one transaction in flight: no accept right after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted a transaction while one is in flight");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr, cmd.acc_wr, cmd.wb_wr}))
    else $error("conflicting store writes");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> (!in_ready_o && !out_valid_o))
    else $error("traffic during clearing sweep");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd.out_load)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
